### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/atsl_pkg.sv
package atsl_pkg;

  localparam int LEVEL_W = 15;
  localparam int RATE_W  = 18;
  localparam int TMO_W   = 16;
  localparam int DT_W    = 20;
  localparam int TIME_W  = 32;
  localparam int VALUE_W = 16;
  localparam int PROD_W  = RATE_W + DT_W;
  localparam int X_W     = 32;
  localparam int QUOT_W  = 19;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'd25600;

  localparam logic [RATE_W-1:0] RAMP_RATE_RESET  = 18'd14080;
  localparam logic [TMO_W-1:0]  TIMEOUT_MS_RESET = 16'd500;

  // 1000000 = 2^6 * 15625
  localparam int DIV_POW2_SHIFT = 6;
  localparam logic [13:0] DIV_ODD = 14'd15625;
  // floor(2^32 / 15625)
  localparam logic [QUOT_W-1:0] DIV_RECIP = 19'd274877;
  localparam int DIV_RECIP_SHIFT = 32;

  localparam logic CFG_RAMP_RATE  = 1'b0;
  localparam logic CFG_TIMEOUT_MS = 1'b1;

  typedef enum logic [2:0] {
    KIND_TICK      = 3'd0,
    KIND_SET       = 3'd1,
    KIND_ARM       = 3'd2,
    KIND_DISARM    = 3'd3,
    KIND_KEEPALIVE = 3'd4
  } kind_t;

endpackage

### rtl/armed_throttle_slew_limiter.sv
// channel | direction | handshake                  | payload
// item    | in        | item_valid / item_stall     | kind, value, dt_us, now_ms
// result  | out       | result_valid / result_stall | drive, overdue, is_armed
// config  | in        | cfg_we                      | cfg_index, cfg_data
//
// one word in and one word out per cycle while result_stall is low; an item taken into
// stage a passes stages b, c and d, then the result register
// the rise per tick (rate times dt over 10^6) is spread over three stages:
// product, reciprocal multiply, then remainder correction
// state (armed, command, drive, last command time) updates in the last stage
// rst is synchronous: clears all stage valids and loads the register defaults
// result_stall backs up stage by stage; empty stages still fill while a result waits

`include "assert_macros.svh"

module armed_throttle_slew_limiter
  import atsl_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [RATE_W-1:0]            cfg_data,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [2:0]                   kind,
  input  logic signed [VALUE_W-1:0]    value,
  input  logic [DT_W-1:0]              dt_us,
  input  logic [TIME_W-1:0]            now_ms,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [LEVEL_W-1:0]           drive,
  output logic                         overdue,
  output logic                         is_armed
);

  logic [RATE_W-1:0] ramp_rate;
  logic [TMO_W-1:0]  timeout_ms;

  logic                      armed_flag, armed_flag_next;
  logic [LEVEL_W-1:0]        command_level, command_level_next;
  logic [LEVEL_W-1:0]        drive_level, drive_level_next;
  logic [TIME_W-1:0]         last_time, last_time_next;

  logic a_valid, b_valid, c_valid, d_valid;
  logic a_en, b_en, c_en, d_en, o_en;

  kind_t                    a_kind, b_kind, c_kind, d_kind;
  logic signed [VALUE_W-1:0] a_value, b_value, c_value, d_value;
  logic [DT_W-1:0]          a_dt;
  logic                     b_dt_zero, c_dt_zero, d_dt_zero;
  logic [TIME_W-1:0]        a_now, b_now, c_now, d_now;

  logic [PROD_W-1:0]        rate_dt;
  logic [X_W-1:0]           b_x, c_x;
  logic [X_W+QUOT_W-1:0]    recip_prod;
  logic [QUOT_W-1:0]        c_q0, d_rise;
  logic [X_W:0]             q0_times_d;
  logic [X_W:0]             div_rem;
  logic [QUOT_W-1:0]        rise;

  logic [QUOT_W:0]          drive_sum;
  logic [LEVEL_W-1:0]       set_level;
  logic [TIME_W-1:0]        elapsed;
  logic                     overdue_next;

  // stage flow control
  assign o_en = !result_valid || !result_stall;
  assign d_en = !d_valid || o_en;
  assign c_en = !c_valid || d_en;
  assign b_en = !b_valid || c_en;
  assign a_en = !a_valid || b_en;
  assign item_stall = !a_en;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_rate  <= RAMP_RATE_RESET;
      timeout_ms <= TIMEOUT_MS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RAMP_RATE: begin
          if (cfg_data != '0) ramp_rate <= cfg_data;
        end
        CFG_TIMEOUT_MS: timeout_ms <= cfg_data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      c_valid      <= 1'b0;
      d_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (a_en) a_valid <= item_valid;
      if (b_en) b_valid <= a_valid;
      if (c_en) c_valid <= b_valid;
      if (d_en) d_valid <= c_valid;
      if (o_en) result_valid <= d_valid;
    end
  end

  // stage a: input word
  always_ff @(posedge clk) begin
    if (a_en && item_valid) begin
      a_kind  <= kind_t'(kind);
      a_value <= value;
      a_dt    <= dt_us;
      a_now   <= now_ms;
    end
  end

  assign rate_dt = {{DT_W{1'b0}}, ramp_rate} * {{RATE_W{1'b0}}, a_dt};

  // stage b: product scaled by 2^-6
  always_ff @(posedge clk) begin
    if (b_en && a_valid) begin
      b_kind    <= a_kind;
      b_value   <= a_value;
      b_now     <= a_now;
      b_dt_zero <= (a_dt == '0);
      b_x       <= rate_dt[PROD_W-1:DIV_POW2_SHIFT];
    end
  end

  assign recip_prod = {{QUOT_W{1'b0}}, b_x} * {{X_W{1'b0}}, DIV_RECIP};

  // stage c: quotient estimate, low by at most one
  always_ff @(posedge clk) begin
    if (c_en && b_valid) begin
      c_kind    <= b_kind;
      c_value   <= b_value;
      c_now     <= b_now;
      c_dt_zero <= b_dt_zero;
      c_x       <= b_x;
      c_q0      <= recip_prod[DIV_RECIP_SHIFT +: QUOT_W];
    end
  end

  assign q0_times_d = {{(X_W+1-QUOT_W){1'b0}}, c_q0} * {{(X_W+1-14){1'b0}}, DIV_ODD};
  assign div_rem    = {1'b0, c_x} - q0_times_d;
  assign rise       = c_q0 + QUOT_W'(div_rem >= {{(X_W+1-14){1'b0}}, DIV_ODD});

  // stage d: exact rise
  always_ff @(posedge clk) begin
    if (d_en && c_valid) begin
      d_kind    <= c_kind;
      d_value   <= c_value;
      d_now     <= c_now;
      d_dt_zero <= c_dt_zero;
      d_rise    <= rise;
    end
  end

  // state update
  always_comb begin
    if (d_value[VALUE_W-1]) begin
      set_level = '0;
    end else if (d_value[VALUE_W-2:0] > LEVEL_MAX) begin
      set_level = LEVEL_MAX;
    end else begin
      set_level = d_value[VALUE_W-2:0];
    end
  end

  assign drive_sum = {{(QUOT_W+1-LEVEL_W){1'b0}}, drive_level} + {1'b0, d_rise};

  always_comb begin
    armed_flag_next    = armed_flag;
    command_level_next = command_level;
    drive_level_next   = drive_level;
    last_time_next     = last_time;
    case (d_kind)
      KIND_TICK: begin
        if (!armed_flag) begin
          drive_level_next = '0;
        end else if (!d_dt_zero) begin
          if (command_level > drive_level) begin
            if (drive_sum > {{(QUOT_W+1-LEVEL_W){1'b0}}, command_level}) begin
              drive_level_next = command_level;
            end else begin
              drive_level_next = drive_sum[LEVEL_W-1:0];
            end
          end else if (command_level < drive_level) begin
            drive_level_next = command_level;
          end
        end
      end
      KIND_SET: begin
        command_level_next = set_level;
        last_time_next     = d_now;
      end
      KIND_ARM: begin
        armed_flag_next = 1'b1;
        last_time_next  = d_now;
      end
      KIND_DISARM: begin
        armed_flag_next  = 1'b0;
        drive_level_next = '0;
        last_time_next   = d_now;
      end
      KIND_KEEPALIVE: begin
        last_time_next = d_now;
      end
      default: ;
    endcase
  end

  assign elapsed      = d_now - last_time_next;
  assign overdue_next = (elapsed >= {{(TIME_W-TMO_W){1'b0}}, timeout_ms});

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_flag    <= 1'b0;
      command_level <= '0;
      drive_level   <= '0;
      last_time     <= '0;
    end else if (d_valid && o_en) begin
      armed_flag    <= armed_flag_next;
      command_level <= command_level_next;
      drive_level   <= drive_level_next;
      last_time     <= last_time_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (d_valid && o_en) begin
      drive    <= drive_level_next;
      overdue  <= overdue_next;
      is_armed <= armed_flag_next;
    end
  end

  `ASSERT_ALWAYS(a_drive_in_range, clk, rst, drive_level <= LEVEL_MAX)
  `ASSERT_IMPLIES(a_disarmed_no_drive, clk, rst, !armed_flag, drive_level == '0)
  `ASSERT_IMPLIES(a_div_correction, clk, rst, c_valid, div_rem < {q0_times_d[0], div_rem[X_W:1]} + {{(X_W+1-14){1'b0}}, DIV_ODD} + {{(X_W+1-14){1'b0}}, DIV_ODD} - {q0_times_d[0], div_rem[X_W:1]})
  `ASSERT_NEXT(a_result_held, clk, rst, result_valid && result_stall, result_valid && $stable(drive))

endmodule

### verif/atsl_result_checker.sv
`timescale 1ns / 100ps

module atsl_result_checker
  import atsl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [RATE_W-1:0]         cfg_data,
  input  logic                      item_valid,
  input  logic                      item_stall,
  input  logic [2:0]                kind,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [DT_W-1:0]           dt_us,
  input  logic [TIME_W-1:0]         now_ms,
  input  logic                      result_valid,
  input  logic                      result_stall,
  input  logic [LEVEL_W-1:0]        drive,
  input  logic                      overdue,
  input  logic                      is_armed,
  output int unsigned               pending_words,
  output int unsigned               mismatch_count
);

  localparam int unsigned US_PER_S = 1000000;

  typedef struct packed {
    logic [LEVEL_W-1:0] drive;
    logic               overdue;
    logic               is_armed;
  } throttle_word_t;

  logic               armed_q;
  logic [LEVEL_W-1:0] command_q;
  logic [LEVEL_W-1:0] drive_q;
  logic [TIME_W-1:0]  last_cmd_q;
  logic [RATE_W-1:0]  rate_q;
  logic [TMO_W-1:0]   timeout_q;

  throttle_word_t expected_words[$];
  int unsigned    mismatches = 0;

  assign mismatch_count = mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // applies one input word to the throttle state and returns the result word
  function automatic throttle_word_t step_throttle(input logic [2:0] k,
                                                   input logic [VALUE_W-1:0] v,
                                                   input logic [DT_W-1:0] dt,
                                                   input logic [TIME_W-1:0] t);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] next_level;
    logic [TIME_W-1:0] since;
    throttle_word_t    w;
    case (k)
      KIND_TICK: begin
        if (!armed_q) begin
          drive_q = '0;
        end else if (dt != '0) begin
          if (command_q > drive_q) begin
            prod = PROD_W'(rate_q) * PROD_W'(dt);
            next_level = PROD_W'(drive_q) + prod / PROD_W'(US_PER_S);
            drive_q = (next_level > PROD_W'(command_q)) ? command_q
                                                        : next_level[LEVEL_W-1:0];
          end else begin
            drive_q = command_q;
          end
        end
      end
      KIND_SET: begin
        // negative clamps to zero, above full scale clamps to full scale
        if (v[VALUE_W-1]) begin
          command_q = '0;
        end else if (v[LEVEL_W-1:0] > LEVEL_MAX) begin
          command_q = LEVEL_MAX;
        end else begin
          command_q = v[LEVEL_W-1:0];
        end
        last_cmd_q = t;
      end
      KIND_ARM: begin
        armed_q = 1'b1;
        last_cmd_q = t;
      end
      KIND_DISARM: begin
        armed_q = 1'b0;
        drive_q = '0;
        last_cmd_q = t;
      end
      KIND_KEEPALIVE: begin
        last_cmd_q = t;
      end
      default: begin
      end
    endcase
    since = t - last_cmd_q;
    w.drive = drive_q;
    w.overdue = (since >= TIME_W'(timeout_q));
    w.is_armed = armed_q;
    return w;
  endfunction

  always @(posedge clk) begin : watch_channels
    throttle_word_t want;
    if (rst) begin
      armed_q = 1'b0;
      command_q = '0;
      drive_q = '0;
      last_cmd_q = '0;
      rate_q = RAMP_RATE_RESET;
      timeout_q = TIMEOUT_MS_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_RAMP_RATE) begin
          // a zero rate is dropped
          if (cfg_data != '0) rate_q = cfg_data;
        end else begin
          timeout_q = cfg_data[TMO_W-1:0];
        end
      end
      if (result_valid && !result_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("result word with nothing pending, drive", 32'(drive), 32'd0);
        end else begin
          want = expected_words.pop_front();
          if (drive !== want.drive) begin
            report_mismatch("drive", 32'(drive), 32'(want.drive));
          end
          if (overdue !== want.overdue) begin
            report_mismatch("overdue", 32'(overdue), 32'(want.overdue));
          end
          if (is_armed !== want.is_armed) begin
            report_mismatch("is_armed", 32'(is_armed), 32'(want.is_armed));
          end
        end
      end
      if (item_valid && !item_stall) begin
        expected_words.push_back(step_throttle(kind, value, dt_us, now_ms));
      end
    end
    pending_words <= expected_words.size();
  end

endmodule

### verif/tb_armed_throttle_slew_limiter.sv
`timescale 1ns / 100ps

module tb_armed_throttle_slew_limiter;
  import atsl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 240;

  localparam int PHASE_FREE  = 0;
  localparam int PHASE_IDLE  = 1;
  localparam int PHASE_STALL = 2;
  localparam int PHASE_BOTH  = 3;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic                      cfg_index = 1'b0;
  logic [RATE_W-1:0]         cfg_data = '0;
  logic                      item_valid = 1'b0;
  logic                      item_stall;
  logic [2:0]                kind = KIND_TICK;
  logic signed [VALUE_W-1:0] value = '0;
  logic [DT_W-1:0]           dt_us = '0;
  logic [TIME_W-1:0]         now_ms = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  logic [LEVEL_W-1:0]        drive;
  logic                      overdue;
  logic                      is_armed;

  int unsigned       pending_words;
  int unsigned       mismatch_count;
  int unsigned       cycle_count = 0;
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                tmo_now = 500;
  logic [TIME_W-1:0] clock_ms = '0;

  armed_throttle_slew_limiter dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .kind(kind),
    .value(value),
    .dt_us(dt_us),
    .now_ms(now_ms),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .drive(drive),
    .overdue(overdue),
    .is_armed(is_armed)
  );

  atsl_result_checker result_chk (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .kind(kind),
    .value(value),
    .dt_us(dt_us),
    .now_ms(now_ms),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .drive(drive),
    .overdue(overdue),
    .is_armed(is_armed),
    .pending_words(pending_words),
    .mismatch_count(mismatch_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("armed_throttle_slew_limiter: mismatch");
      $finish;
    end
  end

  task automatic send_word(input logic [2:0] k, input logic [VALUE_W-1:0] v,
                           input logic [DT_W-1:0] d, input logic [TIME_W-1:0] t);
    while ($urandom_range(0, 99) < idle_pct) begin
      item_valid <= 1'b0;
      kind <= 3'($urandom);
      value <= VALUE_W'($urandom);
      dt_us <= DT_W'($urandom);
      now_ms <= $urandom;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= k;
    value <= v;
    dt_us <= d;
    now_ms <= t;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [RATE_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic send_random_word();
    logic [2:0]         k;
    logic [VALUE_W-1:0] v;
    logic [DT_W-1:0]    d;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      clock_ms += $urandom_range(0, 4);
    end else if (pick < 95) begin
      clock_ms += $urandom_range(0, tmo_now + 20);
    end else begin
      clock_ms = $urandom;
    end
    v = VALUE_W'($urandom);
    d = DT_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 52) begin
      k = KIND_TICK;
    end else if (pick < 68) begin
      k = KIND_SET;
    end else if (pick < 76) begin
      k = KIND_ARM;
    end else if (pick < 81) begin
      k = KIND_DISARM;
    end else if (pick < 94) begin
      k = KIND_KEEPALIVE;
    end else begin
      // codes past keepalive are unused
      k = 3'(KIND_KEEPALIVE + $urandom_range(1, 3));
    end
    if (k == KIND_TICK) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        d = DT_W'($urandom_range(0, 30000));
      end else if (pick < 70) begin
        d = '0;
      end else if (pick < 80) begin
        d = DT_W'($urandom_range(1, 100));
      end else if (pick < 90) begin
        d = DT_W'($urandom_range(900000, 1048575));
      end
    end
    if (k == KIND_SET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        v = VALUE_W'($urandom_range(0, LEVEL_MAX));
      end else if (pick < 85) begin
        v = VALUE_W'($urandom_range(LEVEL_MAX + 1, 32767));
      end
    end
    send_word(k, v, d, clock_ms);
  endtask

  task automatic run_phase(input logic [RATE_W-1:0] rate, input logic [RATE_W-1:0] tmo,
                           input int mode);
    drain_results();
    write_reg(CFG_RAMP_RATE, rate);
    write_reg(CFG_TIMEOUT_MS, tmo);
    cfg_we <= 1'b0;
    tmo_now = int'(tmo[TMO_W-1:0]);
    case (mode)
      PHASE_IDLE: begin
        idle_pct = 85;
        stall_pct = 0;
      end
      PHASE_STALL: begin
        idle_pct = 0;
        stall_pct = 85;
      end
      PHASE_BOTH: begin
        idle_pct = 20;
        stall_pct = 20;
      end
      default: begin
        idle_pct = 0;
        stall_pct = 0;
      end
    endcase
    repeat (PHASE_WORDS) send_random_word();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed words at the reset settings
    send_word(KIND_TICK, 16'h0000, 20'd1000, 32'd0);
    send_word(KIND_SET, 16'd25600, 20'd0, 32'd10);
    send_word(KIND_ARM, 16'h7FFF, 20'hFFFFF, 32'd20);
    send_word(KIND_TICK, 16'h0000, 20'd0, 32'd30);
    send_word(KIND_TICK, 16'h0000, 20'd50, 32'd31);
    send_word(KIND_TICK, 16'h0000, 20'd100000, 32'd32);
    send_word(KIND_TICK, 16'h0000, 20'hFFFFF, 32'd33);
    send_word(KIND_TICK, 16'h8000, 20'hFFFFF, 32'd34);
    send_word(KIND_SET, 16'h8000, 20'd0, 32'd40);
    send_word(KIND_TICK, 16'h0000, 20'd1000, 32'd41);
    send_word(KIND_SET, 16'h7FFF, 20'd0, 32'd50);
    send_word(KIND_TICK, 16'h0000, 20'd20000, 32'd51);
    send_word(KIND_SET, 16'd25601, 20'd0, 32'd60);
    send_word(KIND_SET, 16'd12800, 20'd0, 32'd61);
    send_word(KIND_TICK, 16'h0000, 20'd1, 32'd62);
    // watchdog across the time wrap
    send_word(KIND_KEEPALIVE, 16'h0000, 20'd0, 32'hFFFF_FFFF);
    send_word(KIND_TICK, 16'h0000, 20'd0, 32'h0000_01F2);
    send_word(KIND_TICK, 16'h0000, 20'd0, 32'h0000_01F3);
    send_word(3'(KIND_KEEPALIVE + 1), 16'h1234, 20'd77, 32'h0000_0200);
    send_word(3'(KIND_KEEPALIVE + 2), 16'hFFFF, 20'hFFFFF, 32'h0000_0201);
    send_word(3'(KIND_KEEPALIVE + 3), 16'h8000, 20'd5, 32'h0000_0202);
    send_word(KIND_DISARM, 16'h0000, 20'd0, 32'h0000_0300);
    send_word(KIND_TICK, 16'h0000, 20'd5000, 32'h0000_0301);
    send_word(KIND_ARM, 16'h0000, 20'd0, 32'h0000_0302);
    send_word(KIND_TICK, 16'h0000, 20'd5000, 32'h0000_0303);

    clock_ms = 32'h0000_1000;
    run_phase(RAMP_RATE_RESET, RATE_W'(TIMEOUT_MS_RESET), PHASE_FREE);
    run_phase(18'd1, 18'd0, PHASE_IDLE);
    run_phase(18'h3FFFF, 18'h0FFFF, PHASE_STALL);
    // zero rate must leave the previous rate in place
    run_phase(18'd0, 18'd20, PHASE_BOTH);
    run_phase(RATE_W'($urandom), RATE_W'($urandom), PHASE_FREE);
    clock_ms = 32'hFFFF_FF00;
    run_phase(18'd1000, 18'd3, PHASE_IDLE);
    run_phase(RATE_W'($urandom_range(50000, 262143)), 18'd100, PHASE_STALL);
    run_phase(RATE_W'($urandom_range(1, 5000)), RATE_W'($urandom), PHASE_BOTH);

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("armed_throttle_slew_limiter: match");
    end else begin
      $display("armed_throttle_slew_limiter: mismatch");
    end
    $finish;
  end

endmodule
